>>> rtl/fcs_pkg.sv
// fcs_pkg: shared types and constants of the firmware chunk sequencer
// no dependencies; used by the interfaces' users, front, queue and back
package fcs_pkg;

  // default header length of a chunk message, in bytes
  localparam int unsigned HEADER_BYTES = 8;

  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_ACCEPTED  = 4'd0,
    ST_DUPLICATE = 4'd1,
    ST_COMPLETE  = 4'd2,
    ST_SHORT     = 4'd3,
    ST_MISMATCH  = 4'd4,
    ST_ZEROTOTAL = 4'd5,
    ST_INACTIVE  = 4'd6,
    ST_TOTALCHG  = 4'd7,
    ST_ORDER     = 4'd8,
    ST_OVERRUN   = 4'd9
  } status_e;

  // classified header as it travels from front to back
  typedef struct packed {
    status_e     pre_status;  // ST_ACCEPTED when the message is well formed
    logic        chunk_zero;
    logic [15:0] chunk_size;
    logic [31:0] declared_total;
    logic [15:0] chunk_number;
  } entry_t;

endpackage

>>> rtl/fcs_hdr_if.sv
// fcs_hdr_if: valid/ready channel carrying one chunk message header per beat
// no dependencies
interface fcs_hdr_if;
  logic        valid;
  logic        ready;
  logic [16:0] message_len;
  logic [15:0] hdr_chunk_size;
  logic [31:0] hdr_total_len;
  logic [15:0] hdr_chunk_number;

  modport source (
    output valid, message_len, hdr_chunk_size, hdr_total_len, hdr_chunk_number,
    input  ready
  );
  modport sink (
    input  valid, message_len, hdr_chunk_size, hdr_total_len, hdr_chunk_number,
    output ready
  );
endinterface

>>> rtl/fcs_res_if.sv
// fcs_res_if: valid/ready channel carrying one sequencer result per beat
// no dependencies
interface fcs_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] bytes_done;
  logic        transfer_complete;

  modport source (
    output valid, status, bytes_done, transfer_complete,
    input  ready
  );
  modport sink (
    input  valid, status, bytes_done, transfer_complete,
    output ready
  );
endinterface

>>> rtl/firmware_chunk_sequencer.sv
// firmware_chunk_sequencer: top level of the chunk header sequencer
// depends on fcs_pkg, fcs_hdr_if, fcs_res_if, fcs_front, fcs_queue, fcs_back
//
//   channel  dir  handshake      beat payload
//   hdr_i    in   valid/ready    message_len, hdr_chunk_size, hdr_total_len,
//                                hdr_chunk_number
//   res_o    out  valid/ready    status, bytes_done, transfer_complete
//
// one header per clock sustained while res_o is not stalled; a header beat
// is written into the queue and the back stage pops it from there into its result
// register, which drives res_o.valid; the back stage sets the rate, doing the
// state update of one header a cycle while res_o is not stalled
// rst_ni clears the transfer state, the queue and the output valid asynchronously
// a stalled res_o holds its beat; hdr_i keeps taking beats until the queue is full
module firmware_chunk_sequencer import fcs_pkg::*; #(
  parameter int unsigned HeaderBytes = HEADER_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcs_hdr_if.sink   hdr_i,
  fcs_res_if.source res_o
);

  // front to queue
  logic   q_push;
  logic   q_ready;
  entry_t q_wr_entry;

  // queue to back
  logic   q_valid;
  logic   q_pop;
  entry_t q_rd_entry;

  // stateless checks: short, size mismatch, zero total
  fcs_front #(
    .HeaderBytes (HeaderBytes)
  ) u_front (
    .hdr_i     (hdr_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .entry_o   (q_wr_entry)
  );

  // decouples the input handshake from the result handshake
  fcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_rd_entry)
  );

  // transfer tracking and result register
  fcs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .entry_i   (q_rd_entry),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

>>> rtl/fcs_front.sv
// fcs_front: accepts header beats and runs the stateless message checks
// depends on fcs_pkg and fcs_hdr_if
module fcs_front import fcs_pkg::*; #(
  parameter int unsigned HeaderBytes = HEADER_BYTES
) (
  fcs_hdr_if.sink  hdr_i,
  input  logic     q_ready_i,
  output logic     q_push_o,
  output entry_t   entry_o
);

  logic [16:0] payload_bytes;
  logic        is_short;
  logic        is_mismatch;
  logic        is_zero_total;

  assign hdr_i.ready = q_ready_i;
  assign q_push_o    = hdr_i.valid & q_ready_i;

  // payload length is only meaningful when the message is not short
  assign payload_bytes = hdr_i.message_len - 17'(HeaderBytes);
  assign is_short      = hdr_i.message_len < 17'(HeaderBytes);
  assign is_mismatch   = payload_bytes != {1'b0, hdr_i.hdr_chunk_size};
  assign is_zero_total = hdr_i.hdr_total_len == 32'd0;

  always_comb begin
    priority if (is_short) begin
      entry_o.pre_status = ST_SHORT;
    end else if (is_mismatch) begin
      entry_o.pre_status = ST_MISMATCH;
    end else if (is_zero_total) begin
      entry_o.pre_status = ST_ZEROTOTAL;
    end else begin
      entry_o.pre_status = ST_ACCEPTED;
    end
    entry_o.chunk_zero     = hdr_i.hdr_chunk_number == 16'd0;
    entry_o.chunk_size     = hdr_i.hdr_chunk_size;
    entry_o.declared_total = hdr_i.hdr_total_len;
    entry_o.chunk_number   = hdr_i.hdr_chunk_number;
  end

endmodule

>>> rtl/fcs_queue.sv
// fcs_queue: small first-in first-out queue of classified headers
// depends on fcs_pkg
module fcs_queue import fcs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign ready_o = count_q != CntW'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QUEUE_AW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/fcs_back.sv
// fcs_back: transfer state, sequencing checks and the registered result
// depends on fcs_pkg and fcs_res_if
module fcs_back import fcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  entry_t   entry_i,
  output logic     q_pop_o,
  fcs_res_if.source res_o
);

  logic        active_q, active_d;
  logic [31:0] total_q, total_d;
  logic [31:0] committed_q, committed_d;
  logic [15:0] next_q, next_d;

  logic        out_valid_q;
  status_e     out_status_q, out_status_d;
  logic [31:0] out_bytes_q, out_bytes_d;
  logic        out_done_q, out_done_d;

  // state as seen after a possible restart on chunk zero
  logic        act_eff;
  logic [31:0] tot_eff;
  logic [31:0] com_eff;
  logic [15:0] nxt_eff;
  logic [32:0] sum;

  assign q_pop_o = q_valid_i & (~out_valid_q | res_o.ready);

  assign res_o.valid             = out_valid_q;
  assign res_o.status            = out_status_q;
  assign res_o.bytes_done        = out_bytes_q;
  assign res_o.transfer_complete = out_done_q;

  always_comb begin
    act_eff = active_q | entry_i.chunk_zero;
    tot_eff = entry_i.chunk_zero ? entry_i.declared_total : total_q;
    com_eff = entry_i.chunk_zero ? 32'd0 : committed_q;
    nxt_eff = entry_i.chunk_zero ? 16'd0 : next_q;
    sum     = {1'b0, com_eff} + {17'd0, entry_i.chunk_size};

    active_d     = active_q;
    total_d      = total_q;
    committed_d  = committed_q;
    next_d       = next_q;
    out_status_d = entry_i.pre_status;
    out_bytes_d  = committed_q;
    out_done_d   = 1'b0;

    if (entry_i.pre_status == ST_ACCEPTED) begin
      active_d    = act_eff;
      total_d     = tot_eff;
      committed_d = com_eff;
      next_d      = nxt_eff;
      out_bytes_d = com_eff;
      priority if (!act_eff) begin
        out_status_d = ST_INACTIVE;
      end else if (entry_i.declared_total != tot_eff) begin
        out_status_d = ST_TOTALCHG;
      end else if (entry_i.chunk_number < nxt_eff) begin
        out_status_d = ST_DUPLICATE;
      end else if (entry_i.chunk_number != nxt_eff) begin
        out_status_d = ST_ORDER;
      end else if (entry_i.chunk_size == 16'd0 || sum > {1'b0, tot_eff}) begin
        out_status_d = ST_OVERRUN;
      end else if (sum[31:0] == tot_eff) begin
        out_status_d = ST_COMPLETE;
        out_bytes_d  = sum[31:0];
        out_done_d   = 1'b1;
      end else begin
        out_status_d = ST_ACCEPTED;
        committed_d  = sum[31:0];
        next_d       = nxt_eff + 16'd1;
        out_bytes_d  = sum[31:0];
      end

      // abort or completion clears the whole transfer
      if (out_status_d == ST_TOTALCHG || out_status_d == ST_ORDER ||
          out_status_d == ST_OVERRUN || out_status_d == ST_COMPLETE) begin
        active_d    = 1'b0;
        total_d     = 32'd0;
        committed_d = 32'd0;
        next_d      = 16'd0;
        if (out_status_d != ST_COMPLETE) begin
          out_bytes_d = 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      total_q     <= 32'd0;
      committed_q <= 32'd0;
      next_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        active_q    <= active_d;
        total_q     <= total_d;
        committed_q <= committed_d;
        next_q      <= next_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_status_q <= out_status_d;
      out_bytes_q  <= out_bytes_d;
      out_done_q   <= out_done_d;
    end
  end

endmodule

>>> dv/fcs_check_pkg.sv
// fcs_check_pkg: header and result beat types and the transfer status checker
// depends on fcs_pkg (status codes, header length)
package fcs_check_pkg;
  import fcs_pkg::*;

  typedef struct packed {
    logic [16:0] message_len;
    logic [15:0] chunk_size;
    logic [31:0] declared_total;
    logic [15:0] chunk_number;
  } chunk_hdr_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] bytes_done;
    logic        complete;
  } chunk_res_t;

  class chunk_status_checker;
    bit          xfer_open;
    bit [31:0]   xfer_total;
    bit [31:0]   xfer_bytes;
    bit [15:0]   xfer_next;
    chunk_res_t  awaited_results[$];
    int unsigned mismatches;

    function new();
      drop_transfer();
      mismatches = 0;
    endfunction

    function void drop_transfer();
      xfer_open  = 1'b0;
      xfer_total = '0;
      xfer_bytes = '0;
      xfer_next  = '0;
    endfunction

    // works out the status of one accepted header and moves the transfer on
    function void note_header(chunk_hdr_t h);
      chunk_res_t r;
      bit [32:0]  sum;
      r.status   = ST_ACCEPTED;
      r.complete = 1'b0;
      if (h.message_len < HEADER_BYTES) begin
        r.status = ST_SHORT;
      end else if (32'(h.message_len) - HEADER_BYTES != 32'(h.chunk_size)) begin
        r.status = ST_MISMATCH;
      end else if (h.declared_total == 32'd0) begin
        r.status = ST_ZEROTOTAL;
      end else begin
        // chunk zero always starts afresh, even over a live transfer
        if (h.chunk_number == 16'd0) begin
          drop_transfer();
          xfer_open  = 1'b1;
          xfer_total = h.declared_total;
        end
        if (!xfer_open) begin
          r.status = ST_INACTIVE;
        end else if (h.declared_total != xfer_total) begin
          drop_transfer();
          r.status = ST_TOTALCHG;
        end else if (h.chunk_number < xfer_next) begin
          r.status = ST_DUPLICATE;
        end else if (h.chunk_number != xfer_next) begin
          drop_transfer();
          r.status = ST_ORDER;
        end else begin
          sum = {1'b0, xfer_bytes} + 33'(h.chunk_size);
          if (h.chunk_size == 16'd0 || sum > {1'b0, xfer_total}) begin
            drop_transfer();
            r.status = ST_OVERRUN;
          end else begin
            xfer_bytes = sum[31:0];
            xfer_next  = xfer_next + 16'd1;
            if (xfer_bytes == xfer_total) begin
              r.status     = ST_COMPLETE;
              r.complete   = 1'b1;
              r.bytes_done = xfer_bytes;
              drop_transfer();
            end
          end
        end
      end
      if (r.status != ST_COMPLETE) r.bytes_done = xfer_bytes;
      awaited_results.push_back(r);
    endfunction

    function void report(string what, chunk_res_t exp, chunk_res_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%t: %s: expected status %0d bytes %0d complete %0b,",
                 $realtime, what, exp.status, exp.bytes_done, exp.complete);
        $display("    got status %0d bytes %0d complete %0b",
                 got.status, got.bytes_done, got.complete);
      end
    endfunction

    function void check_result(chunk_res_t got);
      chunk_res_t exp;
      if (awaited_results.size() == 0) begin
        exp = '0;
        report("result beat with none outstanding", exp, got);
      end else begin
        exp = awaited_results.pop_front();
        if (got.status !== exp.status || got.bytes_done !== exp.bytes_done ||
            got.complete !== exp.complete) begin
          report("result mismatch", exp, got);
        end
      end
    endfunction
  endclass

endpackage

>>> dv/tb_firmware_chunk_sequencer.sv
// tb_firmware_chunk_sequencer: self-checking bench for the chunk header sequencer
// depends on fcs_pkg, fcs_hdr_if, fcs_res_if, fcs_check_pkg and the rtl
// directed corner beats, then random transfers mixed with noise under random stalls
module tb_firmware_chunk_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import fcs_pkg::*;
  import fcs_check_pkg::*;

  // stop figure for the random part, counted over every header beat
  localparam int unsigned HeaderTarget = 1550;
  // generous ceiling: ~1600 beats plus the long hold-off
  localparam int unsigned CycleLimit   = 500000;
  // long receiver hold-off, well past what the queue and output register can absorb
  localparam int unsigned HoldOffCycles = 400;

  logic clk_i;
  logic rst_ni;

  fcs_hdr_if hdr_if ();
  fcs_res_if res_if ();

  firmware_chunk_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hdr_i  (hdr_if),
    .res_o  (res_if)
  );

  chunk_status_checker status_check = new();

  int unsigned headers_sent;
  int unsigned burst_left;
  bit          no_gaps;
  bit          holdoff_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: if the run has not wound up by now, something is stuck
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // header sender: bursts of random length with a random idle gap, possibly none, between them;
  // valid stays high across back-to-back beats and is dropped only for a gap or a drain pause
  task automatic send_hdr(input logic [16:0] len, input logic [15:0] size,
                          input logic [31:0] total, input logic [15:0] number);
    chunk_hdr_t  h;
    int unsigned gap;
    h.message_len    = len;
    h.chunk_size     = size;
    h.declared_total = total;
    h.chunk_number   = number;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        hdr_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    hdr_if.valid            <= 1'b1;
    hdr_if.message_len      <= h.message_len;
    hdr_if.hdr_chunk_size   <= h.chunk_size;
    hdr_if.hdr_total_len    <= h.declared_total;
    hdr_if.hdr_chunk_number <= h.chunk_number;
    do @(posedge clk_i); while (hdr_if.ready !== 1'b1);
    status_check.note_header(h);
    headers_sent++;
  endtask

  // sender goes quiet until every outstanding result has been seen
  task automatic pause_until_drained();
    hdr_if.valid <= 1'b0;
    @(posedge clk_i);
    while (status_check.awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // headers outside any sensible transfer: random fields, short, well formed with a
  // random total and number, zero total, payloads near the 16 bit ceiling, random restarts
  task automatic send_noise();
    logic [15:0] size;
    size = 16'($urandom);
    case ($urandom_range(0, 5))
      0: send_hdr(17'($urandom_range(0, 65543)), size, $urandom, 16'($urandom));
      1: send_hdr(17'($urandom_range(0, HEADER_BYTES - 1)), size, $urandom, 16'($urandom));
      2: send_hdr(17'(size + HEADER_BYTES), size, $urandom, 16'($urandom));
      3: send_hdr(17'(size + HEADER_BYTES), size, 32'd0, 16'($urandom_range(0, 3)));
      4: begin
        size = 16'($urandom_range(65528, 65535));
        send_hdr(17'(size + HEADER_BYTES), size, $urandom, 16'($urandom));
      end
      default: send_hdr(17'(size + HEADER_BYTES), size, $urandom, 16'd0);
    endcase
  endtask

  // one well-formed transfer with random sizes, sprinkled with duplicates,
  // malformed beats and restarts, and sometimes broken off by an abort
  task automatic run_transfer();
    logic [31:0] total;
    logic [31:0] done;
    logic [31:0] remaining;
    logic [31:0] bad_total;
    logic [15:0] num;
    int unsigned cap;
    int unsigned size;
    int unsigned pick;
    int unsigned steps;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: total = $urandom_range(1, 3000);
      14, 15, 16: total = $urandom_range(3001, 300000);
      17, 18: total = $urandom | 32'd1;
      default: total = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 3))
      0: cap = total / $urandom_range(1, 6) + 1;
      1: cap = 16;
      2: cap = 2048;
      default: cap = 65535;
    endcase
    if (cap > 65535) cap = 65535;
    done  = '0;
    num   = '0;
    steps = $urandom_range(3, 40);
    for (int k = 0; k < steps; k++) begin
      pick = (k == 0) ? 0 : $urandom_range(0, 99);
      if (pick >= 90 && pick < 92) begin
        // restart over a live transfer, same total
        num  = '0;
        done = '0;
        pick = 0;
      end
      if (pick < 78) begin
        remaining = total - done;
        size = $urandom_range(1, cap);
        if (remaining <= 65535 && (remaining <= size || $urandom_range(0, 5) == 0))
          size = remaining;
        send_hdr(17'(size + HEADER_BYTES), 16'(size), total, num);
        done = done + size;
        num  = num + 16'd1;
        if (done == total) return;
      end else if (pick < 84 && num >= 2) begin
        // stale chunk number: ignored
        size = $urandom_range(1, cap);
        send_hdr(17'(size + HEADER_BYTES), 16'(size), total,
                 16'($urandom_range(1, num - 1)));
      end else if (pick < 92) begin
        // malformed beat, must leave the transfer alone
        size = $urandom_range(0, cap);
        case ($urandom_range(0, 2))
          0: send_hdr(17'($urandom_range(0, HEADER_BYTES - 1)), 16'(size), total, num);
          1: send_hdr(17'(size + HEADER_BYTES + $urandom_range(1, 9)), 16'(size), total, num);
          default: send_hdr(17'(size + HEADER_BYTES), 16'(size), 32'd0, num);
        endcase
      end else begin
        remaining = total - done;
        case ($urandom_range(0, 3))
          0: begin
            bad_total = total + $urandom_range(1, 1000);
            if (bad_total == 32'd0) bad_total = 32'd1;
            send_hdr(17'(1 + HEADER_BYTES), 16'd1, bad_total, num);
          end
          1: send_hdr(17'(1 + HEADER_BYTES), 16'd1, total,
                      num + 16'($urandom_range(1, 500)));
          2: send_hdr(17'(HEADER_BYTES), 16'd0, total, num);
          default: begin
            if (remaining < 65535) begin
              size = $urandom_range(remaining + 1, 65535);
              send_hdr(17'(size + HEADER_BYTES), 16'(size), total, num);
            end else begin
              send_hdr(17'(HEADER_BYTES), 16'd0, total, num);
            end
          end
        endcase
        return;
      end
    end
  endtask

  // result receiver: checks every accepted beat, stalls on a rotating pattern
  // of its own and honours a long hold-off request from the stimulus side
  initial begin
    chunk_res_t  got;
    logic [15:0] pattern;
    int unsigned phase_left;
    int unsigned hold_left;
    res_if.ready <= 1'b0;
    pattern    = 16'hFFFF;
    phase_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.status     = status_e'(res_if.status);
        got.bytes_done = res_if.bytes_done;
        got.complete   = res_if.transfer_complete;
        status_check.check_result(got);
      end
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0, 1: pattern = 16'hFFFF;
            2: pattern = 16'($urandom);
            default: pattern = 16'($urandom) | 16'($urandom);
          endcase
          if (pattern == 16'd0) pattern = 16'h8000;
        end
        res_if.ready <= pattern[phase_left % 16];
        phase_left--;
      end
    end
  end

  // stimulus and end of run
  initial begin
    bit did_holdoff;
    bit did_pause;
    rst_ni                  <= 1'b0;
    hdr_if.valid            <= 1'b0;
    hdr_if.message_len      <= '0;
    hdr_if.hdr_chunk_size   <= '0;
    hdr_if.hdr_total_len    <= '0;
    hdr_if.hdr_chunk_number <= '0;
    headers_sent = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    holdoff_req  = 1'b0;
    did_holdoff  = 1'b0;
    did_pause    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners, starting with no transfer open
    send_hdr(17'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);         // short, empty message
    send_hdr(17'd7, 16'd0, 32'd100, 16'd0);                     // short by one byte
    send_hdr(17'd100, 16'd10, 32'd100, 16'd0);                  // size mismatch
    send_hdr(17'h1FFFF, 16'hFFFF, 32'd5, 16'd0);                // payload wider than 16 bits
    send_hdr(17'd8, 16'd0, 32'd0, 16'd0);                       // zero total
    send_hdr(17'd18, 16'd10, 32'd100, 16'd3);                   // nothing open
    send_hdr(17'd18, 16'd10, 32'd100, 16'd0);                   // start
    send_hdr(17'd28, 16'd20, 32'd100, 16'd1);                   // accepted
    send_hdr(17'd28, 16'd20, 32'd100, 16'd1);                   // duplicate
    send_hdr(17'd78, 16'd70, 32'd100, 16'd2);                   // completes at 100
    send_hdr(17'd9, 16'd1, 32'd100, 16'd3);                     // closed again
    send_hdr(17'd65543, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);        // widest chunk, largest total
    send_hdr(17'd9, 16'd1, 32'hFFFF_FFFE, 16'd1);               // total changed
    send_hdr(17'd13, 16'd5, 32'd50, 16'd0);
    send_hdr(17'd13, 16'd5, 32'd50, 16'd5);                     // out of order
    send_hdr(17'd13, 16'd5, 32'd50, 16'd0);
    send_hdr(17'd8, 16'd0, 32'd50, 16'd1);                      // empty chunk
    send_hdr(17'd48, 16'd40, 32'd50, 16'd0);
    send_hdr(17'd28, 16'd20, 32'd50, 16'd1);                    // overrun
    send_hdr(17'd12, 16'd4, 32'd50, 16'd0);
    send_hdr(17'd14, 16'd6, 32'd60, 16'd0);                     // restart over a live one
    send_hdr(17'd62, 16'd54, 32'd60, 16'd1);                    // completes at 60
    send_hdr(17'd65543, 16'hFFFF, 32'd65535, 16'd0);            // single chunk transfer
    send_hdr(17'd9, 16'd1, 32'd7, 16'hFFFF);                    // highest chunk number
    pause_until_drained();

    // random part
    while (headers_sent < HeaderTarget) begin
      if (!did_holdoff && headers_sent > 500) begin
        // receiver holds off while the sender keeps pushing: the queue fills
        // and hdr_i has to back-pressure
        did_holdoff = 1'b1;
        no_gaps     = 1'b1;
        holdoff_req = 1'b1;
        repeat (3) run_transfer();
        repeat (10) send_noise();
        no_gaps = 1'b0;
      end
      if (!did_pause && headers_sent > 1000) begin
        did_pause = 1'b1;
        pause_until_drained();
      end
      if ($urandom_range(0, 99) < 85) run_transfer();
      else repeat ($urandom_range(1, 3)) send_noise();
    end

    pause_until_drained();
    repeat (8) @(posedge clk_i);
    if (status_check.mismatches == 0 && status_check.awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fcs_pkg.sv
rtl/fcs_hdr_if.sv
rtl/fcs_res_if.sv
rtl/fcs_front.sv
rtl/fcs_queue.sv
rtl/fcs_back.sv
rtl/firmware_chunk_sequencer.sv
dv/fcs_check_pkg.sv
dv/tb_firmware_chunk_sequencer.sv
